// ===== rtl/lfu_pkg.sv =====
// Package for the LFU replacement policy: default sizes, field widths, op codes and FSM states.
package lfu_pkg;

  localparam int DEF_SETS       = 64;
  localparam int DEF_WAYS       = 8;
  localparam int DEF_COUNT_BITS = 16;

  localparam int OP_W    = 2;
  localparam int SET_W   = 6;
  localparam int WAY_W   = 3;
  localparam int VCNT_W  = 16;

  typedef enum logic [OP_W-1:0] {
    OP_INVALIDATE = 2'd0,
    OP_TOUCH      = 2'd1,
    OP_INSERT     = 2'd2,
    OP_VICTIM     = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MODIFY,
    ST_SCAN,
    ST_EMIT
  } state_t;

endpackage

// ===== rtl/lfu_if.sv =====
// Valid/ready channel interfaces for request items and victim result items.
interface lfu_req_if;
  logic                       valid;
  logic                       ready;
  logic [lfu_pkg::OP_W-1:0]   op;
  logic [lfu_pkg::SET_W-1:0]  set_index;
  logic [lfu_pkg::WAY_W-1:0]  way;

  modport source (output valid, output op, output set_index, output way, input ready);
  modport sink   (input valid, input op, input set_index, input way, output ready);
endinterface

interface lfu_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [lfu_pkg::WAY_W-1:0]   victim_way;
  logic [lfu_pkg::VCNT_W-1:0]  victim_count;

  modport source (output valid, output victim_way, output victim_count, input ready);
  modport sink   (input valid, input victim_way, input victim_count, output ready);
endinterface

// ===== rtl/lfu_ram.sv =====
// Generic simple dual-port RAM with registered read.
module lfu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                       wr_data,
  input  logic                                   rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                       rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/lfu_replacement_policy_core.sv =====
// LFU replacement policy core: per-set way counters in a row RAM, serial victim scan.
// Update ops (invalidate, touch, insert): accept, then row write-back in ST_MODIFY.
// Out-of-range updates are dropped in the accept cycle.
// Victim query: row read at accept, serial scan on one shared comparator (skipped for an
// out-of-range set), then the output register loads once free; next accept after that load.
// After rst the RAM is cleared one row a cycle, with req.ready low.
module lfu_replacement_policy_core #(
  parameter int SETS       = lfu_pkg::DEF_SETS,
  parameter int WAYS       = lfu_pkg::DEF_WAYS,
  parameter int COUNT_BITS = lfu_pkg::DEF_COUNT_BITS
) (
  input  logic      clk,
  input  logic      rst,
  lfu_req_if.sink   req,
  lfu_rsp_if.source rsp
);
  import lfu_pkg::*;

  localparam int SW = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int WW = $clog2(WAYS);
  localparam int RW = WAYS * COUNT_BITS;
  localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;
  localparam logic [COUNT_BITS-1:0] CNT_ONE = COUNT_BITS'(1);

  state_t state, state_next;

  op_t                   op_q;
  logic [SW-1:0]         set_q;
  logic [WW-1:0]         way_q;
  logic [WW-1:0]         idx;
  logic [WW-1:0]         best_way;
  logic [COUNT_BITS-1:0] best_cnt;
  logic [SW-1:0]         clr_addr;

  logic                  out_valid;
  logic [WAY_W-1:0]      out_way;
  logic [VCNT_W-1:0]     out_cnt;

  logic                  acc;
  logic                  set_ok;
  logic                  way_ok;
  op_t                   op_in;
  logic                  emit_load;

  logic                  wr_en;
  logic [SW-1:0]         wr_addr;
  logic [RW-1:0]         wr_data;
  logic                  rd_en;
  logic [SW-1:0]         rd_addr;
  logic [RW-1:0]         rd_data;

  logic [COUNT_BITS-1:0] cur_cnt;
  logic [COUNT_BITS-1:0] upd_cnt;
  logic [RW-1:0]         new_row;
  logic [COUNT_BITS-1:0] scan_cnt;

  lfu_ram #(
    .WIDTH (RW),
    .DEPTH (SETS)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign acc    = req.valid && req.ready;
  assign op_in  = op_t'(req.op);
  assign set_ok = 32'(req.set_index) < SETS;
  assign way_ok = 32'(req.way) < WAYS;

  // read-modify-write of one way within the row
  always_comb begin
    cur_cnt = rd_data[way_q*COUNT_BITS +: COUNT_BITS];
    unique case (op_q)
      OP_INVALIDATE: upd_cnt = '0;
      OP_TOUCH:      upd_cnt = (cur_cnt == CNT_MAX) ? cur_cnt : cur_cnt + CNT_ONE;
      OP_INSERT:     upd_cnt = CNT_ONE;
      OP_VICTIM:     upd_cnt = cur_cnt;
    endcase
    for (int w = 0; w < WAYS; w++) begin
      new_row[w*COUNT_BITS +: COUNT_BITS] = (WW'(w) == way_q) ? upd_cnt
                                          : rd_data[w*COUNT_BITS +: COUNT_BITS];
    end
  end

  assign scan_cnt = rd_data[idx*COUNT_BITS +: COUNT_BITS];

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (clr_addr == SW'(SETS - 1)) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (acc) begin
          if (op_in == OP_VICTIM) begin
            state_next = set_ok ? ST_SCAN : ST_EMIT;
          end else if (set_ok && way_ok) begin
            state_next = ST_MODIFY;
          end
        end
      end
      ST_MODIFY: state_next = ST_IDLE;
      ST_SCAN: begin
        if (idx == WW'(WAYS - 1)) state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (!out_valid || rsp.ready) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    req.ready = (state == ST_IDLE);
    wr_en     = (state == ST_CLEAR) || (state == ST_MODIFY);
    wr_addr   = (state == ST_CLEAR) ? clr_addr : set_q;
    wr_data   = (state == ST_CLEAR) ? '0 : new_row;
    rd_en     = acc;
    rd_addr   = SW'(req.set_index);
    emit_load = (state == ST_EMIT) && (!out_valid || rsp.ready);
  end

  assign rsp.valid        = out_valid;
  assign rsp.victim_way   = out_way;
  assign rsp.victim_count = out_cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_addr  <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) clr_addr <= clr_addr + SW'(1);
      if (emit_load) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      op_q     <= op_in;
      set_q    <= SW'(req.set_index);
      way_q    <= WW'(req.way);
      idx      <= '0;
      best_way <= '0;
      best_cnt <= '0;
    end
    if (state == ST_SCAN) begin
      idx <= idx + WW'(1);
      if ((idx == '0) || (scan_cnt < best_cnt)) begin
        best_way <= idx;
        best_cnt <= scan_cnt;
      end
    end
    if (emit_load) begin
      out_way <= WAY_W'(best_way);
      out_cnt <= VCNT_W'(best_cnt);
    end
  end

endmodule

// ===== rtl/lfu_checker.sv =====
// Port-level assertions for the LFU replacement policy core, with bind.
module lfu_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      req_valid,
  input logic                      req_ready,
  input logic                      rsp_valid,
  input logic                      rsp_ready,
  input logic [lfu_pkg::WAY_W-1:0]  victim_way,
  input logic [lfu_pkg::VCNT_W-1:0] victim_count
);

  // stalled result holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(victim_way) && $stable(victim_count))
    else $error("result changed while stalled");

  // clearing pass keeps the request side closed
  a_clear_busy: assert property (@(posedge clk) rst |=> !req_ready)
    else $error("ready during clearing pass");

  // a result never appears right after an accept
  a_no_fast_rsp: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !$rose(rsp_valid))
    else $error("result too early after accept");

  // a new result is loaded only while the core is busy
  a_rsp_from_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(!req_ready))
    else $error("result rose while core idle");

endmodule

bind lfu_replacement_policy_core lfu_checker u_lfu_checker (
  .clk          (clk),
  .rst          (rst),
  .req_valid    (req.valid),
  .req_ready    (req.ready),
  .rsp_valid    (rsp.valid),
  .rsp_ready    (rsp.ready),
  .victim_way   (rsp.victim_way),
  .victim_count (rsp.victim_count)
);

// ===== verif/lfu_replacement_policy_checker.sv =====
// Checker for the LFU replacement policy core: tracks way counters and scores victim results.
module lfu_replacement_policy_checker #(
  parameter int SETS       = lfu_pkg::DEF_SETS,
  parameter int WAYS       = lfu_pkg::DEF_WAYS,
  parameter int COUNT_BITS = lfu_pkg::DEF_COUNT_BITS
) (
  input  logic clk,
  input  logic rst,
  lfu_req_if   req,
  lfu_rsp_if   rsp,
  output int   errors,
  output int   pending
);
  timeunit 1ns;
  timeprecision 1ps;

  import lfu_pkg::*;

  typedef struct packed {
    logic [WAY_W-1:0]  way;
    logic [VCNT_W-1:0] count;
  } victim_t;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  logic [COUNT_BITS-1:0] way_counts [SETS][WAYS];
  victim_t               victim_q[$];

  function automatic victim_t lowest_count_way(int unsigned s);
    victim_t               v;
    logic [COUNT_BITS-1:0] best;
    int unsigned           best_way;
    best     = '0;
    best_way = 0;
    if (s < SETS) begin
      best = way_counts[s][0];
      for (int w = 1; w < WAYS; w++) begin
        if (way_counts[s][w] < best) begin
          best     = way_counts[s][w];
          best_way = w;
        end
      end
    end
    v.way   = best_way[WAY_W-1:0];
    v.count = VCNT_W'(best);
    return v;
  endfunction

  initial begin
    errors  = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    victim_t got;
    victim_t want;
    int unsigned s;
    int unsigned w;
    if (rst) begin
      for (int i = 0; i < SETS; i++) begin
        for (int j = 0; j < WAYS; j++) begin
          way_counts[i][j] = '0;
        end
      end
      victim_q.delete();
    end else begin
      if (rsp.valid && rsp.ready) begin
        got.way   = rsp.victim_way;
        got.count = rsp.victim_count;
        if (victim_q.size() == 0) begin
          $error("unexpected result: victim_way %0d victim_count %0d", got.way, got.count);
          errors++;
        end else begin
          want = victim_q.pop_front();
          if (got.way !== want.way) begin
            $error("victim_way: expected %0d, actual %0d", want.way, got.way);
            errors++;
          end
          if (got.count !== want.count) begin
            $error("victim_count: expected %0d, actual %0d", want.count, got.count);
            errors++;
          end
        end
      end
      if (req.valid && req.ready) begin
        s = 32'(req.set_index);
        w = 32'(req.way);
        if (op_t'(req.op) == OP_VICTIM) begin
          victim_q.push_back(lowest_count_way(s));
        end else if (s < SETS && w < WAYS) begin
          case (op_t'(req.op))
            OP_INVALIDATE: way_counts[s][w] = '0;
            OP_TOUCH: begin
              if (way_counts[s][w] != COUNT_MAX) way_counts[s][w] = way_counts[s][w] + 1'b1;
            end
            default: way_counts[s][w] = COUNT_BITS'(1);
          endcase
        end
      end
    end
    pending = victim_q.size();
  end

endmodule

// ===== verif/lfu_replacement_policy_core_tb.sv =====
// Testbench top for the LFU replacement policy core: clock, reset, request and response traffic.
module lfu_replacement_policy_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lfu_pkg::*;

  localparam int SETS        = DEF_SETS;
  localparam int WAYS        = DEF_WAYS;
  localparam int COUNT_BITS  = DEF_COUNT_BITS;
  localparam int RANDOM_OPS  = 750;
  localparam int CYCLE_LIMIT = 200000;

  logic clk;
  logic rst;
  int   errors;
  int   pending;
  int   burst_left;
  bit   hold_rsp;

  lfu_req_if req_ch ();
  lfu_rsp_if rsp_ch ();

  lfu_replacement_policy_core #(
    .SETS       (SETS),
    .WAYS       (WAYS),
    .COUNT_BITS (COUNT_BITS)
  ) DUT (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  lfu_replacement_policy_checker #(
    .SETS       (SETS),
    .WAYS       (WAYS),
    .COUNT_BITS (COUNT_BITS)
  ) victim_check (
    .clk     (clk),
    .rst     (rst),
    .req     (req_ch),
    .rsp     (rsp_ch),
    .errors  (errors),
    .pending (pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("DONE: errors detected");
    $finish;
  end

  // Called at a falling edge; returns at the falling edge after the item is taken.
  task automatic send_req(op_t op, logic [SET_W-1:0] s, logic [WAY_W-1:0] w, bit paced);
    int gap;
    if (paced && burst_left == 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 12);
      if (gap > 0) begin
        req_ch.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    if (paced) burst_left--;
    req_ch.valid     <= 1'b1;
    req_ch.op        <= op;
    req_ch.set_index <= s;
    req_ch.way       <= w;
    do @(posedge clk); while (!req_ch.ready);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    req_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  function automatic op_t random_op();
    int r;
    r = $urandom_range(0, 99);
    if (r < 20) return OP_VICTIM;
    if (r < 55) return OP_TOUCH;
    if (r < 80) return OP_INSERT;
    return OP_INVALIDATE;
  endfunction

  function automatic logic [SET_W-1:0] random_set();
    if ($urandom_range(0, 9) < 7) return SET_W'($urandom_range(0, 7));
    return SET_W'($urandom_range(0, 63));
  endfunction

  // Response side: phases of full rate, random stalls and sparse ready, plus one long hold.
  initial begin
    int phase_left;
    int mode;
    int hold_left;
    phase_left = 0;
    mode       = 0;
    hold_left  = 0;
    rsp_ch.ready <= 1'b0;
    forever begin
      @(negedge clk);
      if (hold_rsp) begin
        hold_left = 400;
        hold_rsp  = 1'b0;
      end
      if (phase_left == 0) begin
        mode       = $urandom_range(0, 2);
        phase_left = $urandom_range(20, 100);
      end
      phase_left--;
      if (hold_left > 0) begin
        hold_left--;
        rsp_ch.ready <= 1'b0;
      end else begin
        case (mode)
          0:       rsp_ch.ready <= 1'b1;
          1:       rsp_ch.ready <= 1'($urandom_range(0, 1));
          default: rsp_ch.ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  initial begin
    op_t op;
    rst              = 1'b1;
    hold_rsp         = 1'b0;
    burst_left       = 0;
    req_ch.valid     <= 1'b0;
    req_ch.op        <= OP_INVALIDATE;
    req_ch.set_index <= '0;
    req_ch.way       <= '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: fresh counters, extreme sets and ways, ties, invalidate
    send_req(OP_VICTIM, 6'd0, 3'd7, 1'b1);
    send_req(OP_INSERT, 6'd63, 3'd7, 1'b1);
    send_req(OP_TOUCH, 6'd63, 3'd7, 1'b1);
    send_req(OP_VICTIM, 6'd63, 3'd0, 1'b1);
    for (int w = 0; w < 7; w++) send_req(OP_INSERT, 6'd63, WAY_W'(w), 1'b1);
    send_req(OP_VICTIM, 6'd63, 3'd5, 1'b1);
    send_req(OP_INVALIDATE, 6'd63, 3'd3, 1'b1);
    send_req(OP_VICTIM, 6'd63, 3'd2, 1'b1);
    send_req(OP_INVALIDATE, 6'd63, 3'd7, 1'b1);
    send_req(OP_TOUCH, 6'd0, 3'd0, 1'b1);
    send_req(OP_VICTIM, 6'd0, 3'd0, 1'b1);
    send_req(OP_TOUCH, 6'd42, 3'd2, 1'b1);
    send_req(OP_VICTIM, 6'd21, 3'd5, 1'b1);
    wait_drained();

    // set 1: all ways inserted, way 0 touched back to back, then invalidated
    for (int w = 0; w < WAYS; w++) send_req(OP_INSERT, 6'd1, WAY_W'(w), 1'b0);
    for (int i = 0; i < 4; i++) send_req(OP_TOUCH, 6'd1, 3'd0, 1'b0);
    send_req(OP_VICTIM, 6'd1, 3'd0, 1'b1);
    send_req(OP_INVALIDATE, 6'd1, 3'd0, 1'b1);
    send_req(OP_VICTIM, 6'd1, 3'd0, 1'b1);

    for (int i = 0; i < RANDOM_OPS; i++) begin
      if (i == 300) hold_rsp = 1'b1;
      if (i == 500) wait_drained();
      op = (i >= 300 && i < 330) ? OP_VICTIM : random_op();
      send_req(op, random_set(), WAY_W'($urandom_range(0, 7)), !(i >= 300 && i < 330));
    end

    wait_drained();
    repeat (WAYS + 4) @(negedge clk);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
